/* sv/rtn_pkg.sv */
// Package: shared sizes, types, microcode ROM and tanh table for the recurrent tanh net step unit.
`timescale 1ns / 1ps

package rtn_pkg;

    // Network sizes
    localparam int N_SENSORS  = 4;
    localparam int N_HIDDEN   = 6;
    localparam int N_RECUR    = 4;
    localparam int N_MOTOR    = 2;
    localparam int VALUE_BITS = 16;

    function automatic int cw(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int N_IN   = N_SENSORS + N_RECUR;
    localparam int HID_W  = N_IN * N_HIDDEN;
    localparam int REC_W  = N_HIDDEN * N_RECUR;
    localparam int MOT_W  = N_HIDDEN * N_MOTOR;
    localparam int WCOUNT = HID_W + REC_W + MOT_W;
    localparam int WA_W   = cw(WCOUNT);

    // Fixed field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 7;
    localparam int WFIELD_W = 16;
    localparam int SENSOR_W = 4;
    localparam int SENS_IW  = cw(SENSOR_W);

    // Arithmetic
    localparam int ACT_W  = 16;
    localparam int FRAC   = 13;
    localparam int ONE_Q  = 8192;
    localparam int ACC_W  = 32;
    localparam int PROD_W = ACT_W + VALUE_BITS;
    localparam int SUM_W  = imax(PROD_W + 1, ACC_W + 1);

    localparam logic signed [ACT_W-1:0] X_POS = ACT_W'(ONE_Q);
    localparam logic signed [ACT_W-1:0] X_NEG = ACT_W'(-ONE_Q);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // tanh table
    localparam int TAB_W   = 14;
    localparam int TIDX_W  = 5;
    localparam int SEG_W   = 4;
    localparam int FRC_W   = 11;
    localparam int TAB_SAT = 16;

    // Counter widths
    localparam int IW = cw(imax(N_IN, N_HIDDEN));
    localparam int JW = cw(imax(N_HIDDEN, imax(N_RECUR, N_MOTOR)));
    localparam int HW = cw(N_HIDDEN);
    localparam int RW = cw(N_RECUR);
    localparam int MW = cw(N_MOTOR);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_CLEAR = 2'd2
    } rtn_action_t;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [INDEX_W-1:0]         weight_index;
        logic signed [WFIELD_W-1:0] weight_value;
        logic [SENSOR_W-1:0]        sensor_bits;
    } rtn_cmd_t;

    typedef struct packed {
        logic [N_HIDDEN-1:0] hidden_bits;
        logic [N_RECUR-1:0]  recurrent_bits;
        logic [N_MOTOR-1:0]  motor_bits;
    } rtn_result_t;

    // Microcode
    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_MAC  = 2'd1,
        OP_ACT  = 2'd2,
        OP_DONE = 2'd3
    } rtn_op_t;

    typedef enum logic [1:0] {
        LAY_HID = 2'd0,
        LAY_REC = 2'd1,
        LAY_MOT = 2'd2
    } rtn_layer_t;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_LOOP_I = 2'd1,
        JMP_LOOP_J = 2'd2,
        JMP_STOP   = 2'd3
    } rtn_jmp_t;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] PC_HMAC  = 4'd0;
    localparam logic [PC_W-1:0] PC_HACT  = 4'd1;
    localparam logic [PC_W-1:0] PC_DRN0  = 4'd2;
    localparam logic [PC_W-1:0] PC_DRN1  = 4'd3;
    localparam logic [PC_W-1:0] PC_DRN2  = 4'd4;
    localparam logic [PC_W-1:0] PC_RMAC  = 4'd5;
    localparam logic [PC_W-1:0] PC_RACT  = 4'd6;
    localparam logic [PC_W-1:0] PC_MMAC  = 4'd7;
    localparam logic [PC_W-1:0] PC_MACT  = 4'd8;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd9;

    typedef struct packed {
        rtn_op_t         op;
        rtn_layer_t      layer;
        rtn_jmp_t        jmp;
        logic [PC_W-1:0] target;
    } rtn_uword_t;

    // Sequencer to datapath, one micro-op per cycle
    typedef struct packed {
        rtn_op_t       op;
        rtn_layer_t    layer;
        logic [IW-1:0] i;
        logic [JW-1:0] j;
        logic          first;
    } rtn_issue_t;

    function automatic rtn_uword_t ucode(input logic [PC_W-1:0] pc);
        rtn_uword_t w;
        w = '{op: OP_NOP, layer: LAY_HID, jmp: JMP_STOP, target: PC_HMAC};
        unique case (pc)
            PC_HMAC: w = '{op: OP_MAC,  layer: LAY_HID, jmp: JMP_LOOP_I, target: PC_HMAC};
            PC_HACT: w = '{op: OP_ACT,  layer: LAY_HID, jmp: JMP_LOOP_J, target: PC_HMAC};
            PC_DRN0: w = '{op: OP_NOP,  layer: LAY_HID, jmp: JMP_NEXT,   target: PC_HMAC};
            PC_DRN1: w = '{op: OP_NOP,  layer: LAY_HID, jmp: JMP_NEXT,   target: PC_HMAC};
            PC_DRN2: w = '{op: OP_NOP,  layer: LAY_HID, jmp: JMP_NEXT,   target: PC_HMAC};
            PC_RMAC: w = '{op: OP_MAC,  layer: LAY_REC, jmp: JMP_LOOP_I, target: PC_RMAC};
            PC_RACT: w = '{op: OP_ACT,  layer: LAY_REC, jmp: JMP_LOOP_J, target: PC_RMAC};
            PC_MMAC: w = '{op: OP_MAC,  layer: LAY_MOT, jmp: JMP_LOOP_I, target: PC_MMAC};
            PC_MACT: w = '{op: OP_ACT,  layer: LAY_MOT, jmp: JMP_LOOP_J, target: PC_MMAC};
            PC_DONE: w = '{op: OP_DONE, layer: LAY_MOT, jmp: JMP_STOP,   target: PC_HMAC};
            default: w = '{op: OP_NOP,  layer: LAY_HID, jmp: JMP_STOP,   target: PC_HMAC};
        endcase
        return w;
    endfunction

    // round(8192 * tanh(k / 4))
    function automatic logic [TAB_W-1:0] tanh_tab(input logic [TIDX_W-1:0] k);
        logic [TAB_W-1:0] t;
        t = 14'd8187;
        unique case (k)
            5'd0:    t = 14'd0;
            5'd1:    t = 14'd2006;
            5'd2:    t = 14'd3786;
            5'd3:    t = 14'd5203;
            5'd4:    t = 14'd6239;
            5'd5:    t = 14'd6949;
            5'd6:    t = 14'd7415;
            5'd7:    t = 14'd7712;
            5'd8:    t = 14'd7897;
            5'd9:    t = 14'd8012;
            5'd10:   t = 14'd8082;
            5'd11:   t = 14'd8125;
            5'd12:   t = 14'd8151;
            5'd13:   t = 14'd8167;
            5'd14:   t = 14'd8177;
            5'd15:   t = 14'd8183;
            default: t = 14'd8187;
        endcase
        return t;
    endfunction

endpackage

/* sv/rtn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rtn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 84
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rtn_seq.sv */
// Microcode sequencer: program counter, loop counters and ROM-driven micro-op issue.
`timescale 1ns / 1ps

module rtn_seq
    import rtn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    output rtn_issue_t issue
);

    logic            run_reg, run_next;
    logic [PC_W-1:0] pc_reg,  pc_next;
    logic [IW-1:0]   i_reg,   i_next;
    logic [JW-1:0]   j_reg,   j_next;
    rtn_uword_t      cw;
    logic            i_last;
    logic            j_last;

    always_comb
    begin
        cw = ucode(pc_reg);

        // inner loop walks the layer's inputs
        i_last = (cw.layer == LAY_HID) ? (i_reg == IW'(N_IN - 1))
                                       : (i_reg == IW'(N_HIDDEN - 1));
        unique case (cw.layer)
            LAY_HID: j_last = (j_reg == JW'(N_HIDDEN - 1));
            LAY_REC: j_last = (j_reg == JW'(N_RECUR - 1));
            LAY_MOT: j_last = (j_reg == JW'(N_MOTOR - 1));
            default: j_last = 1'b1;
        endcase

        run_next = run_reg;
        pc_next  = pc_reg;
        i_next   = i_reg;
        j_next   = j_reg;

        if (go)
        begin
            run_next = 1'b1;
            pc_next  = PC_HMAC;
            i_next   = '0;
            j_next   = '0;
        end
        else if (run_reg)
        begin
            unique case (cw.jmp)
                JMP_NEXT:
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
                JMP_LOOP_I:
                begin
                    if (!i_last)
                    begin
                        i_next  = i_reg + IW'(1);
                        pc_next = cw.target;
                    end
                    else
                    begin
                        i_next  = '0;
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
                JMP_LOOP_J:
                begin
                    if (!j_last)
                    begin
                        j_next  = j_reg + JW'(1);
                        pc_next = cw.target;
                    end
                    else
                    begin
                        j_next  = '0;
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
                JMP_STOP:
                begin
                    run_next = 1'b0;
                end
            endcase
        end

        issue.op    = run_reg ? cw.op : OP_NOP;
        issue.layer = cw.layer;
        issue.i     = i_reg;
        issue.j     = j_reg;
        issue.first = (i_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= PC_HMAC;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
    end

endmodule

/* sv/rtn_dp.sv */
// Datapath: operand select, multiply, saturating accumulate, piecewise-linear tanh, layer state.
`timescale 1ns / 1ps

module rtn_dp
    import rtn_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic                         clr,
    input  logic [SENSOR_W-1:0]          sensor_bits,
    input  rtn_issue_t                   issue,
    output logic [WA_W-1:0]              raddr,
    input  logic signed [VALUE_BITS-1:0] rdata,
    output logic                         done,
    output rtn_result_t                  result
);

    // held sensors and layer values
    logic [SENSOR_W-1:0]     sens_reg;
    logic signed [ACT_W-1:0] rec_reg [N_RECUR];
    logic signed [ACT_W-1:0] hid_reg [N_HIDDEN];
    logic [N_HIDDEN-1:0]     hb_reg;
    logic [N_RECUR-1:0]      rb_reg;
    logic [N_MOTOR-1:0]      mb_reg;

    // stage 1: weight read returns
    rtn_op_t                 p1_op_reg;
    rtn_layer_t              p1_layer_reg;
    logic [JW-1:0]           p1_j_reg;
    logic                    p1_first_reg;
    logic signed [ACT_W-1:0] p1_x_reg, x_next;

    // stage 2: product ready, accumulate or capture
    rtn_op_t                  p2_op_reg;
    rtn_layer_t               p2_layer_reg;
    logic [JW-1:0]            p2_j_reg;
    logic                     p2_first_reg;
    logic signed [PROD_W-1:0] p2_prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // stage 3: tanh interpolation
    rtn_op_t          p3_op_reg, p3_op_next;
    rtn_layer_t       p3_layer_reg;
    logic [JW-1:0]    p3_j_reg;
    logic             p3_neg_reg;
    logic             p3_sat_reg, sat_next;
    logic [SEG_W-1:0] p3_seg_reg, seg_next;
    logic [FRC_W-1:0] p3_frc_reg, frc_next;

    logic [IW+SENS_IW-1:0]   i_ext;
    logic [IW-1:0]           r_idx;
    logic                    s_bit;
    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_W-1:0] xs;
    logic [ACC_W-1:0]        xa;
    logic [TAB_W-1:0]        t0, t1, td, y;
    logic [TAB_W+FRC_W-1:0]  tm;
    logic signed [ACT_W-1:0] y_s, act_val;
    logic                    act_pos;

    // issue: weight address and operand
    always_comb
    begin
        unique case (issue.layer)
            LAY_HID: raddr = WA_W'(issue.i) * WA_W'(N_HIDDEN) + WA_W'(issue.j);
            LAY_REC: raddr = WA_W'(HID_W) + WA_W'(issue.i) * WA_W'(N_RECUR)
                             + WA_W'(issue.j);
            LAY_MOT: raddr = WA_W'(HID_W + REC_W) + WA_W'(issue.i) * WA_W'(N_MOTOR)
                             + WA_W'(issue.j);
            default: raddr = '0;
        endcase

        // sensors beyond the field read as clear
        i_ext = (IW + SENS_IW)'(issue.i);
        s_bit = (i_ext < (IW + SENS_IW)'(SENSOR_W)) ? sens_reg[i_ext[SENS_IW-1:0]] : 1'b0;
        r_idx = issue.i - IW'(N_SENSORS);

        if (issue.layer == LAY_HID)
        begin
            if (issue.i < IW'(N_SENSORS))
            begin
                x_next = s_bit ? X_POS : X_NEG;
            end
            else
            begin
                x_next = rec_reg[r_idx[RW-1:0]];
            end
        end
        else
        begin
            x_next = hid_reg[issue.i[HW-1:0]];
        end
    end

    // stage 1 -> 2 multiply, stage 2 accumulate with saturation
    always_comb
    begin
        prod_next = p1_x_reg * rdata;

        sum = {{(SUM_W-PROD_W){p2_prod_reg[PROD_W-1]}}, p2_prod_reg};
        if (!p2_first_reg)
        begin
            sum = sum + {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        end
        if ((&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1]))
        begin
            acc_next = sum[ACC_W-1:0];
        end
        else
        begin
            acc_next = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end

        // floor shift, magnitude, segment split
        xs       = acc_reg >>> FRAC;
        xa       = acc_reg[ACC_W-1] ? ACC_W'(-xs) : ACC_W'(xs);
        sat_next = |xa[ACC_W-1:SEG_W+FRC_W];
        seg_next = xa[SEG_W+FRC_W-1:FRC_W];
        frc_next = xa[FRC_W-1:0];

        p3_op_next = OP_NOP;
        if (p2_op_reg == OP_DONE)
        begin
            p3_op_next = OP_DONE;
        end
        else if (p2_op_reg == OP_ACT && p2_layer_reg != LAY_MOT)
        begin
            p3_op_next = OP_ACT;
        end
    end

    // stage 3: interpolate between table points
    always_comb
    begin
        t0 = tanh_tab(TIDX_W'(p3_seg_reg));
        t1 = tanh_tab(TIDX_W'(p3_seg_reg) + TIDX_W'(1));
        td = t1 - t0;
        tm = (TAB_W+FRC_W)'(td) * (TAB_W+FRC_W)'(p3_frc_reg);
        y  = p3_sat_reg ? tanh_tab(TIDX_W'(TAB_SAT)) : t0 + tm[TAB_W+FRC_W-1:FRC_W];
        y_s     = ACT_W'(y);
        act_val = p3_neg_reg ? -y_s : y_s;
        act_pos = !p3_neg_reg && (y != '0);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_op_reg <= OP_NOP;
            p2_op_reg <= OP_NOP;
            p3_op_reg <= OP_NOP;
            for (int k = 0; k < N_RECUR; k++)
            begin
                rec_reg[k] <= '0;
            end
        end
        else
        begin
            p1_op_reg <= issue.op;
            p2_op_reg <= p1_op_reg;
            p3_op_reg <= p3_op_next;
            if (clr)
            begin
                for (int k = 0; k < N_RECUR; k++)
                begin
                    rec_reg[k] <= '0;
                end
            end
            else if (p3_op_reg == OP_ACT && p3_layer_reg == LAY_REC)
            begin
                rec_reg[p3_j_reg[RW-1:0]] <= act_val;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sens_reg <= sensor_bits;
        end

        p1_layer_reg <= issue.layer;
        p1_j_reg     <= issue.j;
        p1_first_reg <= issue.first;
        p1_x_reg     <= x_next;

        p2_layer_reg <= p1_layer_reg;
        p2_j_reg     <= p1_j_reg;
        p2_first_reg <= p1_first_reg;
        p2_prod_reg  <= prod_next;

        if (p2_op_reg == OP_MAC)
        begin
            acc_reg <= acc_next;
        end
        if (p2_op_reg == OP_ACT && p2_layer_reg == LAY_MOT)
        begin
            mb_reg[p2_j_reg[MW-1:0]] <= !acc_reg[ACC_W-1] && (acc_reg != '0);
        end

        p3_layer_reg <= p2_layer_reg;
        p3_j_reg     <= p2_j_reg;
        p3_neg_reg   <= acc_reg[ACC_W-1];
        p3_sat_reg   <= sat_next;
        p3_seg_reg   <= seg_next;
        p3_frc_reg   <= frc_next;

        if (p3_op_reg == OP_ACT)
        begin
            if (p3_layer_reg == LAY_HID)
            begin
                hid_reg[p3_j_reg[HW-1:0]] <= act_val;
                hb_reg[p3_j_reg[HW-1:0]]  <= act_pos;
            end
            else
            begin
                rb_reg[p3_j_reg[RW-1:0]] <= act_pos;
            end
        end
    end

    assign done                  = (p3_op_reg == OP_DONE);
    assign result.hidden_bits    = hb_reg;
    assign result.recurrent_bits = rb_reg;
    assign result.motor_bits     = mb_reg;

endmodule

/* sv/recurrent_tanh_net_step_unit.sv */
// Top level: recurrent tanh network step unit with microcoded MAC datapath.
`timescale 1ns / 1ps

// Usage
//   Command channel: a beat is taken at a rising edge with start high and busy low.
//   cmd.action selects the work:
//     write  - stores cmd.weight_value at cmd.weight_index in the weight RAM that
//              same edge; indexes past the last weight are dropped. No result.
//     clear  - zeroes the four stored recurrent outputs that edge. No result.
//     step   - runs one network step on cmd.sensor_bits; busy rises next cycle.
//     code 3 is ignored.
//   Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall it, so it must take the beat in that cycle.
//   Schedule: a step issues one micro-op per cycle from the microcode ROM, in
//   turn through the single shared multiply-accumulate unit and the weight RAM's
//   one read port; the pipeline then drains, and done rises at the same edge at
//   which busy falls. A new step is taken only while busy is low. Writes and
//   clears complete at the accepting edge and leave busy low.
//   Reset: clears the sequencer, pipeline control and recurrent outputs. Weight
//   RAM contents are undefined until written.

module recurrent_tanh_net_step_unit
    import rtn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  rtn_cmd_t    cmd,
    output logic        busy,
    output logic        done,
    output rtn_result_t result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg;
    logic                  accept;
    logic                  go;
    logic                  clr;
    logic                  we;
    logic [WA_W-1:0]       waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [WA_W-1:0]       raddr;
    logic [VALUE_BITS-1:0] rdata;
    logic                  dp_done;
    rtn_issue_t            issue;

    assign accept = start && !busy_reg;
    assign go     = accept && (cmd.action == ACT_STEP);
    assign clr    = accept && (cmd.action == ACT_CLEAR);
    assign we     = accept && (cmd.action == ACT_WRITE)
                    && (32'(cmd.weight_index) < 32'(WCOUNT));
    assign waddr  = WA_W'(cmd.weight_index);

    // weight word: low VALUE_BITS bits, zero-filled above the field
    generate
        if (VALUE_BITS <= WFIELD_W)
        begin : g_wnarrow
            assign wdata = cmd.weight_value[VALUE_BITS-1:0];
        end
        else
        begin : g_wwide
            assign wdata = {{(VALUE_BITS-WFIELD_W){1'b0}}, cmd.weight_value};
        end
    endgenerate

    rtn_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WCOUNT)
    ) u_wram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    rtn_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .issue (issue)
    );

    rtn_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .clr         (clr),
        .sensor_bits (cmd.sensor_bits),
        .issue       (issue),
        .raddr       (raddr),
        .rdata       (rdata),
        .done        (dp_done),
        .result      (result)
    );

    // busy spans the whole step; it drops with the result beat
    always_comb
    begin
        busy_next = busy_reg;
        if (go)
        begin
            busy_next = 1'b1;
        end
        else if (dp_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= dp_done;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* sv/rtn_chk.sv */
// Port-level checker for the recurrent tanh net step unit, bound to the top level.
`timescale 1ns / 1ps

module rtn_chk
    import rtn_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input rtn_cmd_t cmd
);

    // a step command occupies the unit
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_STEP) |=> busy)
        else $error("step beat did not raise busy");

    // writes, clears and unknown codes finish in the accepting cycle
    a_short_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action != ACT_STEP) |=> !busy)
        else $error("non-step beat raised busy");

    // busy ends only with a result beat
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // a result beat comes with the unit free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind recurrent_tanh_net_step_unit rtn_chk u_rtn_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
);
